@@ design/imupd_pkg.sv @@
// ----------------------------------------------------------------------------
// imupd_pkg
// Shared constants and types for the IMU packet deframer.
// ----------------------------------------------------------------------------
package imupd_pkg;

  localparam int PKT_LEN    = 11;
  localparam int NUM_TYPES  = 3;
  localparam int AXES       = 3;
  localparam int NUM_VALUES = NUM_TYPES * AXES;
  localparam int SKIP_W     = 4;

  localparam logic [7:0] HDR_BYTE   = 8'h55;
  localparam logic [7:0] TYPE_ACCEL = 8'h51;
  localparam logic [7:0] TYPE_RATE  = 8'h52;
  localparam logic [7:0] TYPE_ANGLE = 8'h53;

  localparam logic [SKIP_W-1:0]    SKIP_AFTER = SKIP_W'(PKT_LEN - 1);
  localparam logic [NUM_TYPES-1:0] ALL_SEEN   = '1;

  typedef logic [PKT_LEN-1:0][7:0] window_t;

  typedef struct packed {
    logic                 good;
    logic [NUM_TYPES-1:0] slot_hot;
  } check_t;

endpackage

@@ design/imupd_if.sv @@
// ----------------------------------------------------------------------------
// imupd_byte_if / imupd_sample_if
// Valid/ready channels for received bytes and for decoded sample sets.
// ----------------------------------------------------------------------------
interface imupd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface imupd_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;
  logic signed [15:0] roll_raw;
  logic signed [15:0] pitch_raw;
  logic signed [15:0] yaw_raw;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  output rate_x, output rate_y, output rate_z,
                  output roll_raw, output pitch_raw, output yaw_raw,
                  input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  input rate_x, input rate_y, input rate_z,
                  input roll_raw, input pitch_raw, input yaw_raw,
                  output ready);
endinterface

@@ design/imupd_check.sv @@
// ----------------------------------------------------------------------------
// imupd_check
// Packet check on an 11-byte window: header, type decode and 8-bit checksum.
// ----------------------------------------------------------------------------
module imupd_check (
  input  imupd_pkg::window_t win,
  output imupd_pkg::check_t  chk
);

  localparam int PAIRS = (imupd_pkg::PKT_LEN - 1) / 2;

  logic [7:0]                      pair_sum [PAIRS];
  logic [7:0]                      total;
  logic [imupd_pkg::NUM_TYPES-1:0] hot;

  always_comb begin
    for (int i = 0; i < PAIRS; i++) begin
      pair_sum[i] = win[2*i] + win[2*i+1];
    end
    total = '0;
    for (int i = 0; i < PAIRS; i++) begin
      total = total + pair_sum[i];
    end
  end

  always_comb begin
    hot = '0;
    case (win[1])
      imupd_pkg::TYPE_ACCEL: hot = 3'b001;
      imupd_pkg::TYPE_RATE:  hot = 3'b010;
      imupd_pkg::TYPE_ANGLE: hot = 3'b100;
      default:               hot = '0;
    endcase
  end

  assign chk.slot_hot = hot;
  assign chk.good     = (win[0] == imupd_pkg::HDR_BYTE) && (hot != '0) &&
                        (win[imupd_pkg::PKT_LEN-1] == total);

endmodule

@@ design/imu_packet_deframer.sv @@
// ----------------------------------------------------------------------------
// imu_packet_deframer
// Slides received bytes through an 11-byte window, validates packets and
// emits all nine raw sensor values once every packet type has been seen.
// ----------------------------------------------------------------------------
// channel   direction  payload                                   handshake
// in_chan   sink       rx_byte[7:0]                              valid/ready
// out_chan  source     accel_xyz, rate_xyz, roll/pitch/yaw [15:0] valid/ready
//
// One byte per cycle unless in_chan stalls; each byte is shifted, checked and
// stored in the cycle of its transfer, and a sample set appears in the result
// register in the next cycle. Throughput is set by the single result register:
// in_chan stalls only while a sample set waits and out_chan is not ready.
// Reset (rst_n low, synchronous) clears window, seen flags and output valid,
// and loads the skip counter with ten to cover the window fill.
// ----------------------------------------------------------------------------
module imu_packet_deframer (
  input  logic                  clk,
  input  logic                  rst_n,
  imupd_byte_if.sink            in_chan,
  imupd_sample_if.source        out_chan
);

  imupd_pkg::window_t                    win_r, win_nxt;
  logic [imupd_pkg::SKIP_W-1:0]          skip_r;
  logic [imupd_pkg::NUM_TYPES-1:0]       seen_r, seen_nxt;
  logic [15:0]                           sample_r [imupd_pkg::NUM_VALUES];
  logic [15:0]                           sample_nxt [imupd_pkg::NUM_VALUES];
  logic [15:0]                           out_r [imupd_pkg::NUM_VALUES];
  logic                                  out_valid_r;
  imupd_pkg::check_t                     chk;
  logic                                  xfer_in;
  logic                                  store;
  logic                                  emit;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign xfer_in       = in_chan.valid && in_chan.ready;

  always_comb begin
    win_nxt = {in_chan.rx_byte, win_r[imupd_pkg::PKT_LEN-1:1]};
  end

  imupd_check u_check (
    .win (win_nxt),
    .chk (chk)
  );

  assign store    = xfer_in && (skip_r == '0) && chk.good;
  assign seen_nxt = seen_r | chk.slot_hot;
  assign emit     = store && (seen_nxt == imupd_pkg::ALL_SEEN);

  always_comb begin
    for (int s = 0; s < imupd_pkg::NUM_TYPES; s++) begin
      for (int j = 0; j < imupd_pkg::AXES; j++) begin
        sample_nxt[s*imupd_pkg::AXES+j] = chk.slot_hot[s] ?
          {win_nxt[2*j+3], win_nxt[2*j+2]} : sample_r[s*imupd_pkg::AXES+j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      skip_r      <= imupd_pkg::SKIP_AFTER;
      seen_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (xfer_in) begin
        win_r <= win_nxt;
        if (skip_r != '0) begin
          skip_r <= skip_r - 1'b1;
        end else if (chk.good) begin
          skip_r <= imupd_pkg::SKIP_AFTER;
        end
      end
      if (store) begin
        seen_r <= emit ? '0 : seen_nxt;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      sample_r <= sample_nxt;
    end
    if (emit) begin
      out_r <= sample_nxt;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.accel_x   = out_r[0];
  assign out_chan.accel_y   = out_r[1];
  assign out_chan.accel_z   = out_r[2];
  assign out_chan.rate_x    = out_r[3];
  assign out_chan.rate_y    = out_r[4];
  assign out_chan.rate_z    = out_r[5];
  assign out_chan.roll_raw  = out_r[6];
  assign out_chan.pitch_raw = out_r[7];
  assign out_chan.yaw_raw   = out_r[8];

  a_skip_range: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r <= imupd_pkg::SKIP_AFTER)
    else $error("skip counter out of range");

  a_no_store_while_skipping: assert property (@(posedge clk) disable iff (!rst_n)
    (xfer_in && skip_r != '0) |-> !store)
    else $error("packet stored during skip");

  a_store_reloads_skip: assert property (@(posedge clk) disable iff (!rst_n)
    store |=> skip_r == imupd_pkg::SKIP_AFTER)
    else $error("skip counter not reloaded after good packet");

  a_emit_clears_seen: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (seen_r == '0) && out_valid_r)
    else $error("seen flags not cleared on emission");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready) |-> !emit)
    else $error("pending sample set overwritten");

endmodule

@@ tb/imu_packet_deframer_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_packet_deframer_test
// Feeds serial byte streams made of good and faulty packets plus noise into
// the deframer. A shadow of the window, skip counter, seen flags and stored
// values predicts every sample set; each transfer on the result channel is
// compared field by field under varied source gaps and sink stalls.
// ----------------------------------------------------------------------------
module imu_packet_deframer_test;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES  = 300;

  typedef logic [imupd_pkg::NUM_VALUES-1:0][15:0] sample_set_t;
  typedef enum int {PKT_GOOD, PKT_BAD_HDR, PKT_BAD_TYPE, PKT_BAD_SUM} pkt_fault_t;

  logic clk = 1'b0;
  logic rst_n;

  imupd_byte_if   in_chan();
  imupd_sample_if out_chan();

  imu_packet_deframer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #1 clk = ~clk;

  // shadow of the deframer state
  logic [7:0]     shift_win [imupd_pkg::PKT_LEN] = '{default: 8'h00};
  logic [3:0]     skip_left = imupd_pkg::SKIP_AFTER;
  logic [2:0]     seen_types = '0;
  sample_set_t    stored_values = '0;
  sample_set_t    expected_sets [$];

  const string field_name [imupd_pkg::NUM_VALUES] = '{"accel_x", "accel_y", "accel_z",
                                                      "rate_x", "rate_y", "rate_z",
                                                      "roll_raw", "pitch_raw", "yaw_raw"};
  const logic [7:0] type_codes [imupd_pkg::NUM_TYPES] =
    '{imupd_pkg::TYPE_ACCEL, imupd_pkg::TYPE_RATE, imupd_pkg::TYPE_ANGLE};

  int failures       = 0;
  int bytes_sent     = 0;
  int sets_predicted = 0;
  int sets_checked   = 0;
  int stall_cycles   = 0;
  int cycle_count    = 0;
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int holds_asked    = 0;

  task automatic track_byte(input logic [7:0] b);
    logic [7:0] sum;
    int slot;
    for (int k = 0; k < imupd_pkg::PKT_LEN - 1; k++) shift_win[k] = shift_win[k + 1];
    shift_win[imupd_pkg::PKT_LEN - 1] = b;
    if (skip_left != 0) begin
      skip_left = skip_left - 1'b1;
      return;
    end
    if (shift_win[0] != imupd_pkg::HDR_BYTE) return;
    case (shift_win[1])
      imupd_pkg::TYPE_ACCEL: slot = 0;
      imupd_pkg::TYPE_RATE:  slot = 1;
      imupd_pkg::TYPE_ANGLE: slot = 2;
      default:               return;
    endcase
    sum = '0;
    for (int k = 0; k < imupd_pkg::PKT_LEN - 1; k++) sum = sum + shift_win[k];
    if (shift_win[imupd_pkg::PKT_LEN - 1] != sum) return;
    for (int a = 0; a < imupd_pkg::AXES; a++)
      stored_values[slot * imupd_pkg::AXES + a] = {shift_win[3 + 2 * a],
                                                   shift_win[2 + 2 * a]};
    seen_types[slot] = 1'b1;
    skip_left = imupd_pkg::SKIP_AFTER;
    if (seen_types == imupd_pkg::ALL_SEEN) begin
      expected_sets.push_back(stored_values);
      sets_predicted++;
      seen_types = '0;
    end
  endtask

  always @(posedge clk) begin
    sample_set_t got;
    sample_set_t want;
    if (rst_n && in_chan.valid && !in_chan.ready) stall_cycles++;
    if (rst_n && in_chan.valid && in_chan.ready) track_byte(in_chan.rx_byte);
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got[0] = out_chan.accel_x;
      got[1] = out_chan.accel_y;
      got[2] = out_chan.accel_z;
      got[3] = out_chan.rate_x;
      got[4] = out_chan.rate_y;
      got[5] = out_chan.rate_z;
      got[6] = out_chan.roll_raw;
      got[7] = out_chan.pitch_raw;
      got[8] = out_chan.yaw_raw;
      sets_checked++;
      if (expected_sets.size() == 0) begin
        $display("%0t: unexpected sample set: expected none, got accel_x %0d", $time,
                 $signed(got[0]));
        failures++;
      end else begin
        want = expected_sets.pop_front();
        for (int k = 0; k < imupd_pkg::NUM_VALUES; k++) begin
          if (got[k] !== want[k]) begin
            $display("%0t: %s expected %0d got %0d", $time, field_name[k],
                     $signed(want[k]), $signed(got[k]));
            failures++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d sample sets outstanding", $time, expected_sets.size());
      $display("imu_packet_deframer_test: FAIL");
      $finish;
    end
  end

  // sink side: random stalls plus long hold-offs on request
  initial begin : sink_side
    int hold_left;
    int holds_served;
    hold_left = 0;
    holds_served = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.rx_byte <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_packet(input logic [7:0] kind, input logic [15:0] w_x,
                             input logic [15:0] w_y, input logic [15:0] w_z,
                             input pkt_fault_t fault);
    logic [7:0] pkt [imupd_pkg::PKT_LEN];
    logic [7:0] sum;
    pkt[0] = imupd_pkg::HDR_BYTE;
    pkt[1] = kind;
    {pkt[3], pkt[2]} = w_x;
    {pkt[5], pkt[4]} = w_y;
    {pkt[7], pkt[6]} = w_z;
    pkt[8] = 8'($urandom);
    pkt[9] = 8'($urandom);
    if (fault == PKT_BAD_HDR) pkt[0] = imupd_pkg::HDR_BYTE ^ (8'h01 << $urandom_range(7));
    if (fault == PKT_BAD_TYPE) begin
      do pkt[1] = 8'($urandom);
      while (pkt[1] == imupd_pkg::TYPE_ACCEL || pkt[1] == imupd_pkg::TYPE_RATE ||
             pkt[1] == imupd_pkg::TYPE_ANGLE);
    end
    sum = '0;
    for (int k = 0; k < imupd_pkg::PKT_LEN - 1; k++) sum = sum + pkt[k];
    pkt[imupd_pkg::PKT_LEN - 1] = (fault == PKT_BAD_SUM) ?
                                  sum ^ 8'($urandom_range(255, 1)) : sum;
    for (int k = 0; k < imupd_pkg::PKT_LEN; k++) send_byte(pkt[k]);
  endtask

  function automatic logic [15:0] random_word();
    case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic pkt_fault_t random_fault();
    case ($urandom_range(2))
      0:       return PKT_BAD_HDR;
      1:       return PKT_BAD_TYPE;
      default: return PKT_BAD_SUM;
    endcase
  endfunction

  task automatic send_random_packet(input int type_idx, input int fault_pct);
    pkt_fault_t fault;
    fault = ($urandom_range(99) < fault_pct) ? random_fault() : PKT_GOOD;
    send_packet(type_codes[type_idx], random_word(), random_word(), random_word(), fault);
  endtask

  task automatic wait_for_all_sets();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (expected_sets.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // first packet lands right after reset, while the window is still filling
  task automatic test_first_sample_set();
    send_packet(imupd_pkg::TYPE_ACCEL, 16'h7fff, 16'h8000, 16'h0000, PKT_GOOD);
    send_packet(imupd_pkg::TYPE_RATE,  16'hffff, 16'h0001, 16'h8000, PKT_GOOD);
    send_packet(imupd_pkg::TYPE_ANGLE, 16'h0000, 16'h7fff, 16'hffff, PKT_GOOD);
    wait_for_all_sets();
  endtask

  task automatic test_rejected_packets();
    send_packet(imupd_pkg::TYPE_ACCEL, 16'h1234, 16'h5678, 16'h9abc, PKT_BAD_HDR);
    send_packet(imupd_pkg::TYPE_ACCEL - 8'h01, 16'h1111, 16'h2222, 16'h3333, PKT_GOOD);
    send_packet(imupd_pkg::TYPE_ANGLE + 8'h01, 16'h4444, 16'h5555, 16'h6666, PKT_GOOD);
    send_packet(imupd_pkg::TYPE_RATE, 16'h7777, 16'h8888, 16'h9999, PKT_BAD_SUM);
    wait_for_all_sets();
  endtask

  // stray header forces a one-byte slide; second accel packet overwrites the first
  task automatic test_resync_and_overwrite();
    send_byte(imupd_pkg::HDR_BYTE);
    send_packet(imupd_pkg::TYPE_ACCEL, 16'h0102, 16'h0304, 16'h0506, PKT_GOOD);
    send_packet(imupd_pkg::TYPE_ACCEL, 16'hfedc, 16'h8001, 16'h7ffe, PKT_GOOD);
    send_packet(imupd_pkg::TYPE_ANGLE, 16'h0a0b, 16'h0c0d, 16'h0e0f, PKT_GOOD);
    send_packet(imupd_pkg::TYPE_RATE,  16'h8000, 16'h7fff, 16'h0000, PKT_GOOD);
    wait_for_all_sets();
  endtask

  task automatic test_traffic(input int src_idle, input int sink_stall,
                              input int min_bytes, input int min_sets);
    int start_bytes;
    int start_sets;
    int first;
    int step;
    int r;
    src_idle_pct   <= src_idle;
    sink_stall_pct <= sink_stall;
    start_bytes = bytes_sent;
    start_sets  = sets_predicted;
    while (bytes_sent - start_bytes < min_bytes || sets_predicted - start_sets < min_sets) begin
      r = $urandom_range(99);
      if (r < 70) begin
        first = $urandom_range(2);
        step  = $urandom_range(1) ? 1 : 2;
        for (int k = 0; k < imupd_pkg::NUM_TYPES; k++)
          send_random_packet((first + k * step) % 3, 8);
      end else if (r < 85) begin
        send_random_packet($urandom_range(2), 0);
      end else if (r < 93) begin
        repeat ($urandom_range(4, 1))
          send_byte($urandom_range(3) == 0 ? imupd_pkg::HDR_BYTE : 8'($urandom));
      end else begin
        send_random_packet($urandom_range(2), 100);
      end
    end
    wait_for_all_sets();
  endtask

  // hold the sink off so the result register fills and the input stalls
  task automatic test_output_backpressure();
    src_idle_pct   <= 0;
    sink_stall_pct <= 0;
    holds_asked    <= holds_asked + 1;
    repeat (4) begin
      for (int k = 0; k < imupd_pkg::NUM_TYPES; k++) send_random_packet(k, 0);
    end
    wait_for_all_sets();
  endtask

  // pause the source until nothing is outstanding, then resume
  task automatic test_idle_pause();
    send_random_packet(0, 0);
    send_random_packet(1, 0);
    wait_for_all_sets();
    send_random_packet(2, 0);
    wait_for_all_sets();
  endtask

  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.rx_byte = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_first_sample_set();
    test_rejected_packets();
    test_resync_and_overwrite();
    test_traffic(0, 0, 200, 5);
    test_traffic(86, 0, 200, 5);
    test_traffic(0, 86, 200, 5);
    test_traffic(30, 30, 200, 5);
    test_output_backpressure();
    test_idle_pause();
    repeat (8) @(posedge clk);
    $display("Sent %0d bytes of good, faulty and noisy packets; checked %0d sample sets.",
             bytes_sent, sets_checked);
    $display("Input stalled %0d cycles under sink hold-off and random stalls.", stall_cycles);
    if (failures == 0) begin
      $display("imu_packet_deframer_test: PASS");
    end else begin
      $display("imu_packet_deframer_test: FAIL");
    end
    $finish;
  end

endmodule

@@ imu_packet_deframer.f @@
design/imupd_pkg.sv
design/imupd_if.sv
design/imupd_check.sv
design/imu_packet_deframer.sv
tb/imu_packet_deframer_test.sv
